@@ rtl/sweep_impedance_trimmed_average_unit_assert.svh @@
// Assertion macros for the sweep impedance trimmed average unit.
`ifndef SWEEP_IMPEDANCE_TRIMMED_AVERAGE_UNIT_ASSERT_SVH
`define SWEEP_IMPEDANCE_TRIMMED_AVERAGE_UNIT_ASSERT_SVH
// Same-cycle implication, sampled on clk_i, off during reset
`define SITAU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, sampled on clk_i, off during reset
`define SITAU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/sitau_pkg.sv @@
// Shared types and constants of the sweep impedance trimmed average unit.
package sitau_pkg;

  // Configuration register indexes
  localparam logic REG_GAIN = 1'b0;
  localparam logic REG_CORR = 1'b1;

  localparam logic [31:0] CORR_RESET = 32'd100604823;

  // Last step indexes of the shared root/divide unit
  localparam logic [5:0] SQRT_LAST = 6'd15;
  localparam logic [5:0] DIV_LAST  = 6'd32;

  typedef enum logic {
    OP_SQRT,
    OP_DIV
  } arith_op_e;

  typedef struct packed {
    logic        start;
    arith_op_e   op;
    logic [31:0] operand;
  } arith_req_t;

  typedef struct packed {
    logic        done;
    logic [32:0] result;
  } arith_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_SUM,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_STORE,
    ST_SORT_KEY,
    ST_SORT_KEYW,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_AVG0,
    ST_AVG0W,
    ST_AVG_RD,
    ST_AVG_ACC,
    ST_MUL,
    ST_OUT
  } state_e;

endpackage

@@ rtl/sweep_impedance_trimmed_average_unit.sv @@
// Per word: squares, a 16-step root, a 33-step divide and a store, from acceptance to ready
// again. The final word adds an insertion sort on the one RAM port pair, then the
// averaging over the trim window, a multiply and the output state.
// One word is in work at a time; in_ready_o is high only in the idle state. Reset (rst_ni,
// async, low) clears sequencer, fill count, overflow flag and config; the RAM is not cleared.
module sweep_impedance_trimmed_average_unit #(
  parameter int DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_addr_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] real_part_i,
  input  logic signed [15:0] imag_part_i,
  input  logic               last_sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        impedance_estimate_o,
  output logic [8:0]         samples_used_o,
  output logic               overflow_flag_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  sitau_pkg::state_e state_q, state_d;

  logic        gain5_q;
  logic [31:0] corr_q;
  logic [16:0] re_q, im_q, re_d, im_d;
  logic        last_q, last_d;
  logic [31:0] sq_q, sq_d;
  logic [63:0] prod_q;
  logic [31:0] mul_a, mul_b;
  logic [15:0] mag_q, mag_d;
  logic [17:0] dvs;
  logic [31:0] rcp_q, rcp_d;
  logic [CW-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d, k_q, k_d, lo, hi;
  logic        ovf_q, ovf_d;
  logic [31:0] key_q, key_d, avg_q, avg_d;
  logic [32:0] avg_sum;
  logic        out_valid_q, out_valid_d;
  logic [31:0] est_q, est_d;
  logic [8:0]  used_q, used_d;
  logic        oflag_q, oflag_d;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;

  sitau_pkg::arith_req_t arq;
  sitau_pkg::arith_rsp_t ars;

  sitau_ram #(.Width(32), .Depth(DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sitau_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (arq),
    .rsp_o  (ars)
  );

  // Trim window and divisor
  assign lo      = (cnt_q >> 1) - (cnt_q >> 2);
  assign hi      = (cnt_q >> 1) + (cnt_q >> 2);
  assign dvs     = gain5_q ? ({mag_q, 2'b00} + {2'b00, mag_q}) : {2'b00, mag_q};
  assign avg_sum = {1'b0, avg_q} + {1'b0, ram_rdata};

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sitau_pkg::ST_IDLE:      if (in_valid_i) state_d = sitau_pkg::ST_SQ_RE;
      sitau_pkg::ST_SQ_RE:     state_d = sitau_pkg::ST_SQ_IM;
      sitau_pkg::ST_SQ_IM:     state_d = sitau_pkg::ST_SUM;
      sitau_pkg::ST_SUM:       state_d = sitau_pkg::ST_SQRT_GO;
      sitau_pkg::ST_SQRT_GO:   state_d = sitau_pkg::ST_SQRT_WAIT;
      sitau_pkg::ST_SQRT_WAIT: if (ars.done) state_d = sitau_pkg::ST_DIV_GO;
      sitau_pkg::ST_DIV_GO:    state_d = sitau_pkg::ST_DIV_WAIT;
      sitau_pkg::ST_DIV_WAIT:  if (ars.done) state_d = sitau_pkg::ST_STORE;
      sitau_pkg::ST_STORE:
        state_d = last_q ? sitau_pkg::ST_SORT_KEY : sitau_pkg::ST_IDLE;
      sitau_pkg::ST_SORT_KEY:
        state_d = (i_q >= cnt_q) ? sitau_pkg::ST_AVG0 : sitau_pkg::ST_SORT_KEYW;
      sitau_pkg::ST_SORT_KEYW: state_d = sitau_pkg::ST_SORT_RD;
      sitau_pkg::ST_SORT_RD:
        state_d = (j_q == '0) ? sitau_pkg::ST_SORT_KEY : sitau_pkg::ST_SORT_CMP;
      sitau_pkg::ST_SORT_CMP:
        state_d = (ram_rdata > key_q) ? sitau_pkg::ST_SORT_RD : sitau_pkg::ST_SORT_KEY;
      sitau_pkg::ST_AVG0:      state_d = sitau_pkg::ST_AVG0W;
      sitau_pkg::ST_AVG0W:     state_d = sitau_pkg::ST_AVG_RD;
      sitau_pkg::ST_AVG_RD:
        state_d = (k_q >= hi) ? sitau_pkg::ST_MUL : sitau_pkg::ST_AVG_ACC;
      sitau_pkg::ST_AVG_ACC:   state_d = sitau_pkg::ST_AVG_RD;
      sitau_pkg::ST_MUL:       state_d = sitau_pkg::ST_OUT;
      sitau_pkg::ST_OUT:
        if (!out_valid_q || out_ready_i) state_d = sitau_pkg::ST_IDLE;
      default:                 state_d = sitau_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    re_d        = re_q;
    im_d        = im_q;
    last_d      = last_q;
    sq_d        = sq_q;
    mag_d       = mag_q;
    rcp_d       = rcp_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    key_d       = key_q;
    avg_d       = avg_q;
    est_d       = est_q;
    used_d      = used_q;
    oflag_d     = oflag_q;
    out_valid_d = out_valid_q;
    mul_a       = {15'd0, re_q};
    mul_b       = {15'd0, re_q};
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = key_q;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    arq.start   = 1'b0;
    arq.op      = sitau_pkg::OP_SQRT;
    arq.operand = sq_q;
    in_ready_o  = (state_q == sitau_pkg::ST_IDLE);

    // drop the word once taken downstream
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      sitau_pkg::ST_IDLE: begin
        // take absolute values; the most negative part maps to 32768
        re_d   = real_part_i[15] ? 17'(-{real_part_i[15], real_part_i})
                                 : {1'b0, real_part_i};
        im_d   = imag_part_i[15] ? 17'(-{imag_part_i[15], imag_part_i})
                                 : {1'b0, imag_part_i};
        last_d = last_sample_i;
      end
      sitau_pkg::ST_SQ_IM: begin
        mul_a = {15'd0, im_q};
        mul_b = {15'd0, im_q};
        sq_d  = prod_q[31:0];
      end
      sitau_pkg::ST_SUM: sq_d = sq_q + prod_q[31:0];
      sitau_pkg::ST_SQRT_GO: arq.start = 1'b1;
      sitau_pkg::ST_SQRT_WAIT: if (ars.done) mag_d = ars.result[15:0];
      sitau_pkg::ST_DIV_GO: begin
        arq.start   = 1'b1;
        arq.op      = sitau_pkg::OP_DIV;
        arq.operand = {14'd0, dvs};
      end
      sitau_pkg::ST_DIV_WAIT: begin
        // saturate on zero magnitude and on a quotient of 2^32
        if (ars.done) rcp_d = (dvs == '0 || ars.result[32]) ? '1 : ars.result[31:0];
      end
      sitau_pkg::ST_STORE: begin
        if (cnt_q < CW'(DEPTH)) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_q[AW-1:0];
          ram_wdata = rcp_q;
          cnt_d     = cnt_q + 1'b1;
        end else begin
          ovf_d = 1'b1;
        end
        i_d = CW'(1);
      end
      sitau_pkg::ST_SORT_KEY: begin
        ram_re    = 1'b1;
        ram_raddr = i_q[AW-1:0];
      end
      sitau_pkg::ST_SORT_KEYW: begin
        key_d = ram_rdata;
        j_d   = i_q;
      end
      sitau_pkg::ST_SORT_RD: begin
        if (j_q == '0) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          i_d       = i_q + 1'b1;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(j_q - 1'b1);
        end
      end
      sitau_pkg::ST_SORT_CMP: begin
        // shift the larger word up, or drop the key in place
        ram_we    = 1'b1;
        ram_waddr = j_q[AW-1:0];
        if (ram_rdata > key_q) begin
          ram_wdata = ram_rdata;
          j_d       = j_q - 1'b1;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      sitau_pkg::ST_AVG0: ram_re = 1'b1;
      sitau_pkg::ST_AVG0W: begin
        avg_d = ram_rdata;
        k_d   = lo;
      end
      sitau_pkg::ST_AVG_RD: begin
        ram_re    = 1'b1;
        ram_raddr = k_q[AW-1:0];
      end
      sitau_pkg::ST_AVG_ACC: begin
        avg_d = avg_sum[32:1];
        k_d   = k_q + 1'b1;
      end
      sitau_pkg::ST_MUL: begin
        mul_a = avg_q;
        mul_b = corr_q;
      end
      sitau_pkg::ST_OUT: begin
        // hold the product while the output slot is busy
        mul_a = avg_q;
        mul_b = corr_q;
        if (!out_valid_q || out_ready_i) begin
          est_d       = prod_q[63:32];
          used_d      = 9'(cnt_q);
          oflag_d     = ovf_q;
          out_valid_d = 1'b1;
          cnt_d       = '0;
          ovf_d       = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sitau_pkg::ST_IDLE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      gain5_q     <= 1'b0;
      corr_q      <= sitau_pkg::CORR_RESET;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && cfg_addr_i == sitau_pkg::REG_GAIN) gain5_q <= cfg_wdata_i[0];
      if (cfg_we_i && cfg_addr_i == sitau_pkg::REG_CORR) corr_q  <= cfg_wdata_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    re_q    <= re_d;
    im_q    <= im_d;
    last_q  <= last_d;
    sq_q    <= sq_d;
    prod_q  <= {32'd0, mul_a} * {32'd0, mul_b};
    mag_q   <= mag_d;
    rcp_q   <= rcp_d;
    i_q     <= i_d;
    j_q     <= j_d;
    k_q     <= k_d;
    key_q   <= key_d;
    avg_q   <= avg_d;
    est_q   <= est_d;
    used_q  <= used_d;
    oflag_q <= oflag_d;
  end

  assign out_valid_o          = out_valid_q;
  assign impedance_estimate_o = est_q;
  assign samples_used_o       = used_q;
  assign overflow_flag_o      = oflag_q;

  `include "sweep_impedance_trimmed_average_unit_assert.svh"

  `SITAU_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CW'(DEPTH))
  `SITAU_ASSERT_NXT(a_accept_starts, in_valid_i && in_ready_o, state_q == sitau_pkg::ST_SQ_RE)
  `SITAU_ASSERT_IMP(a_sort_j_le_i, state_q == sitau_pkg::ST_SORT_RD || state_q == sitau_pkg::ST_SORT_CMP, j_q <= i_q && i_q < cnt_q)

endmodule

@@ rtl/sitau_ram.sv @@
// Generic simple dual-port RAM with registered read.
module sitau_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/sitau_arith.sv @@
// Shared iterative unit: integer square root and 2^32 reciprocal divide.
module sitau_arith (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sitau_pkg::arith_req_t req_i,
  output sitau_pkg::arith_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  sitau_pkg::arith_op_e op_q, op_d;
  logic [5:0]           cnt_q, cnt_d;
  logic [31:0]          src_q, src_d;
  logic [17:0]          dvs_q, dvs_d;
  logic [19:0]          rem_q, rem_d;
  logic [32:0]          acc_q, acc_d;

  logic [19:0] shifted, trial, diff;
  logic        ge, last_step, is_sqrt;

  // One digit step: shift in, trial subtract, keep or restore
  always_comb begin
    is_sqrt   = (op_q == sitau_pkg::OP_SQRT);
    shifted   = is_sqrt ? {rem_q[17:0], src_q[31:30]} : {rem_q[18:0], src_q[31]};
    trial     = is_sqrt ? {acc_q[17:0], 2'b01} : {2'b00, dvs_q};
    diff      = shifted - trial;
    ge        = (shifted >= trial);
    last_step = (cnt_q == (is_sqrt ? sitau_pkg::SQRT_LAST : sitau_pkg::DIV_LAST));
  end

  // Sequence the steps
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    src_d  = src_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    acc_d  = acc_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      cnt_d  = '0;
      src_d  = (req_i.op == sitau_pkg::OP_SQRT) ? req_i.operand : 32'h8000_0000;
      dvs_d  = req_i.operand[17:0];
      rem_d  = '0;
      acc_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? diff : shifted;
      acc_d = {acc_q[31:0], ge};
      src_d = is_sqrt ? {src_q[29:0], 2'b00} : {src_q[30:0], 1'b0};
      cnt_d = cnt_q + 6'd1;
      if (last_step) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= sitau_pkg::OP_SQRT;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    acc_q <= acc_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = acc_q;

endmodule

@@ test/sweep_impedance_trimmed_average_unit_tb.sv @@
// Testbench for the sweep impedance trimmed average unit, with a built-in predictor.
module sweep_impedance_trimmed_average_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = 256;
  localparam int STALL_MAX  = 400000;
  localparam int SETTLE_CYC = 100;

  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               last;
  } sweep_point_t;

  typedef struct {
    logic [31:0] estimate;
    logic [8:0]  used;
    logic        ovf;
  } estimate_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_addr_i;
  logic [31:0]        cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [15:0] real_part_i;
  logic signed [15:0] imag_part_i;
  logic               last_sample_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [31:0]        impedance_estimate_o;
  logic [8:0]         samples_used_o;
  logic               overflow_flag_o;

  sweep_impedance_trimmed_average_unit #(.DEPTH(DEPTH)) dut (.*);

  // Predictor state and configuration copy
  logic [31:0]  recip_store[DEPTH];
  int unsigned  fill_count;
  logic         ovf_seen;
  logic         gain5;
  logic [31:0]  corr;

  sweep_point_t point_q[$];
  estimate_t    estimate_q[$];

  int  errors, words_in, sweeps_done, ovf_sweeps;
  bit  word_taken, result_taken, idle_on;
  int  send_gap, recv_gap, stall_cnt;

  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  function automatic logic [31:0] point_reciprocal(logic signed [15:0] re,
                                                   logic signed [15:0] im, logic g5);
    logic [16:0] ar, ai;
    logic [63:0] sq, root, bitv, d, q;
    ar = re[15] ? 17'h10000 - {1'b0, re} : {1'b0, re};
    ai = im[15] ? 17'h10000 - {1'b0, im} : {1'b0, im};
    sq = ar * ar + ai * ai;
    // bit-by-bit integer root
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > sq) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (sq >= root + bitv) begin
        sq = sq - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    d = root * (g5 ? 64'd5 : 64'd1);
    if (d == 0) return 32'hFFFF_FFFF;
    q = (64'd1 << 32) / d;
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  // Store one point and, on the last one, compute the trimmed estimate
  task automatic predict_sweep(sweep_point_t p);
    logic [31:0] vals[$];
    logic [63:0] avg;
    estimate_t   e;
    int          n;
    if (fill_count < DEPTH) begin
      recip_store[fill_count] = point_reciprocal(p.re, p.im, gain5);
      fill_count++;
    end else begin
      ovf_seen = 1'b1;
    end
    if (p.last) begin
      n = fill_count;
      avg = 0;
      if (n > 0) begin
        for (int i = 0; i < n; i++) vals.push_back(recip_store[i]);
        vals.sort();
        avg = vals[0];
        for (int i = n / 2 - n / 4; i < n / 2 + n / 4; i++) avg = (avg + vals[i]) >> 1;
      end
      e.estimate = (avg * {32'd0, corr}) >> 32;
      e.used = n[8:0];
      e.ovf = ovf_seen;
      estimate_q.push_back(e);
      if (ovf_seen) ovf_sweeps++;
      fill_count = 0;
      ovf_seen = 1'b0;
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h (sweep %0d)", what, got, want, sweeps_done);
    errors++;
  endtask

  // Monitor: take words and results at the rising edge
  always @(posedge clk_i) begin
    estimate_t e;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_sweep('{real_part_i, imag_part_i, last_sample_i});
        word_taken = 1;
        words_in++;
      end
      if (out_valid_o && out_ready_i) begin
        result_taken = 1;
        sweeps_done++;
        if (estimate_q.size() == 0) begin
          report_mismatch("unexpected result", impedance_estimate_o, 0);
        end else begin
          e = estimate_q.pop_front();
          if (impedance_estimate_o !== e.estimate)
            report_mismatch("impedance_estimate", impedance_estimate_o, e.estimate);
          if (samples_used_o !== e.used)
            report_mismatch("samples_used", samples_used_o, e.used);
          if (overflow_flag_o !== e.ovf)
            report_mismatch("overflow_flag", overflow_flag_o, e.ovf);
        end
      end
      // watchdog on handshake silence
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= STALL_MAX) begin
        $display("timeout: no handshake for %0d cycles", STALL_MAX);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Driver: present the next word at the falling edge after its gap
  always @(negedge clk_i) begin
    sweep_point_t p;
    logic nv;
    nv = in_valid_i;
    if (word_taken) begin
      nv = 1'b0;
      word_taken = 0;
      send_gap = idle_on ? $urandom_range(0, 8) : 0;
    end
    if (!nv && rst_ni) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (point_q.size() > 0) begin
        p = point_q.pop_front();
        real_part_i   <= p.re;
        imag_part_i   <= p.im;
        last_sample_i <= p.last;
        nv = 1'b1;
      end
    end
    in_valid_i <= nv;
  end

  // Receiver: stall a random number of cycles before each result
  always @(negedge clk_i) begin
    if (result_taken) begin
      result_taken = 0;
      recv_gap = idle_on ? $urandom_range(0, 8) : 0;
    end
    if (recv_gap > 0) begin
      recv_gap--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic cfg_write(logic idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == sitau_pkg::REG_GAIN) gain5 = val[0];
    else corr = val;
  endtask

  // Hold until the block has drained, checked at clock edges, then let it settle
  task automatic drain;
    while (point_q.size() != 0 || in_valid_i || estimate_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic add_point(int re, int im, bit last);
    point_q.push_back('{re[15:0], im[15:0], last});
  endtask

  function automatic logic [15:0] rand_part();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return $urandom_range(0, 3) - 1;
      3: return $urandom_range(0, 200);
      default: return $urandom();
    endcase
  endfunction

  task automatic add_sweep(int len);
    for (int i = 0; i < len; i++) add_point(rand_part(), rand_part(), i == len - 1);
  endtask

  function automatic logic [31:0] rand_corr();
    case ($urandom_range(0, 4))
      0: return 32'hFFFF_FFFF;
      1: return 32'd0;
      2: return sitau_pkg::CORR_RESET;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int queued, phase;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_addr_i = sitau_pkg::REG_GAIN; cfg_wdata_i = '0;
    in_valid_i = 1'b0; real_part_i = '0; imag_part_i = '0; last_sample_i = 1'b0;
    out_ready_i = 1'b0;
    fill_count = 0; ovf_seen = 1'b0; gain5 = 1'b0; corr = sitau_pkg::CORR_RESET;
    errors = 0; words_in = 0; sweeps_done = 0; ovf_sweeps = 0;
    send_gap = 0; recv_gap = 0; stall_cnt = 0; idle_on = 1;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, zero magnitude, unit magnitude, single-sample sweep
    add_point(-32768, -32768, 0);
    add_point(32767, 32767, 0);
    add_point(0, 0, 0);
    add_point(1, 0, 0);
    add_point(0, -32768, 0);
    add_point(-1, 0, 1);
    add_point(3, 4, 1);
    drain();
    cfg_write(sitau_pkg::REG_GAIN, 32'd1);
    cfg_write(sitau_pkg::REG_CORR, 32'hFFFF_FFFF);
    add_point(-32768, 32767, 0);
    add_point(0, 1, 1);
    add_point(0, 0, 1);
    add_point(5, -12, 0);
    add_point(-32768, 0, 0);
    add_point(100, 100, 1);
    drain();
    cfg_write(sitau_pkg::REG_CORR, 32'd0);
    cfg_write(sitau_pkg::REG_GAIN, 32'd0);
    add_point(7, 7, 0);
    add_point(32767, -32768, 1);
    drain();

    // Random phases; one phase overfills the store
    queued = 15;
    phase = 0;
    while (queued < 1550) begin
      cfg_write(sitau_pkg::REG_GAIN, $urandom_range(0, 1));
      cfg_write(sitau_pkg::REG_CORR, rand_corr());
      idle_on = (phase % 4) != 1;
      if (phase == 3) begin
        add_sweep(DEPTH + $urandom_range(1, 6));
        queued += DEPTH + 3;
      end
      repeat ($urandom_range(3, 10)) begin
        int len;
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        add_sweep(len);
        queued += len;
      end
      drain();
      phase++;
    end
    idle_on = 1;

    $display("covered %0d words in %0d sweeps over %0d config phases", words_in,
             sweeps_done, phase + 3);
    $display("%0d sweeps overfilled the store; %0d mismatches", ovf_sweeps, errors);
    if (errors == 0 && estimate_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/sitau_pkg.sv
rtl/sitau_ram.sv
rtl/sitau_arith.sv
rtl/sweep_impedance_trimmed_average_unit.sv
test/sweep_impedance_trimmed_average_unit_tb.sv
